// ----- design/vwap_pkg.sv -----
// ============================================================================
// VWAP package
// Fixed widths of the running sums, the divider and the result, and the
// status group that the serial arithmetic units report to the controller.
// ============================================================================
package vwap_pkg;

   // Window length register.
   localparam int CfgWidth = 11;
   // Running sum of bar products and of volumes.
   localparam int WsumWidth = 60;
   localparam int VsumWidth = 34;
   // Divisor three times the volume sum.
   localparam int DenWidth = VsumWidth + 2;
   // Result price, Q16.8.
   localparam int OutWidth = 24;

   // Status of a multi-cycle serial unit.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ----- design/vwap_ram.sv -----
// ============================================================================
// VWAP generic RAM
// Single write port, single read port with registered read data.
// ============================================================================
module vwap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/vwap_serial_mul.sv -----
// ============================================================================
// VWAP serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle and
// keeps the low P_W bits of the product.
// ============================================================================
module vwap_serial_mul
   import vwap_pkg::*;
#(
   parameter int A_W = 26,
   parameter int B_W = 24,
   parameter int P_W = 50
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [A_W-1:0]  mcand,
   input  logic [B_W-1:0]  mplier,
   output logic [P_W-1:0]  product,
   output unit_status_type status
);

   localparam int CntW = $clog2(B_W + 1);

   logic [P_W-1:0]  acc_ff, acc_in;
   logic [P_W-1:0]  mcand_ff, mcand_in;
   logic [B_W-1:0]  mplier_ff, mplier_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = P_W'(mcand);
         mplier_in = mplier;
         cnt_in    = CntW'(B_W);
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - 1'b1;
         done_in   = (cnt_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign product     = acc_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

// ----- design/vwap_serial_div.sv -----
// ============================================================================
// VWAP serial divider
// Restoring radix-2 divider: one quotient bit per cycle over the whole
// dividend; the low result bits of the quotient are kept.
// ============================================================================
module vwap_serial_div
   import vwap_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WsumWidth-1:0] dividend,
   input  logic [DenWidth-1:0]  divisor,
   output logic [OutWidth-1:0]  quotient,
   output unit_status_type      status
);

   localparam int CntW = $clog2(WsumWidth + 1);

   logic [WsumWidth-1:0] num_ff, num_in;
   logic [DenWidth-1:0]  den_ff, den_in;
   logic [DenWidth-1:0]  rem_ff, rem_in;
   logic [OutWidth-1:0]  quo_ff, quo_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DenWidth:0]    shifted;
   logic [DenWidth:0]    trial;

   always_comb begin
      shifted = {rem_ff, num_ff[WsumWidth-1]};
      trial   = shifted - {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = dividend;
         den_in = divisor;
         rem_in = '0;
         quo_in = '0;
         cnt_in = CntW'(WsumWidth);
      end else if (cnt_ff != '0) begin
         // The remainder stays below the divisor, so the shifted value
         // never needs more than one extra bit.
         if (!trial[DenWidth]) begin
            rem_in = trial[DenWidth-1:0];
            quo_in = {quo_ff[OutWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[DenWidth-1:0];
            quo_in = {quo_ff[OutWidth-2:0], 1'b0};
         end
         num_in  = num_ff << 1;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

// ----- design/sliding_window_vwap.sv -----
// ============================================================================
// Sliding window VWAP
// Moving volume weighted average of the typical price (high+low+close)/3
// over the last window_length bars, built around serial arithmetic units.
// ============================================================================
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ------------------------------
//  req_      in         req_tvalid/req_tready  high, low, close, volume
//  rsp_      out        rsp_tvalid/rsp_tready  average price, zero-volume flag
//  csr_      in         csr_wr_en              window_length
//
//  A bar passes through the bit-serial multiplier while the window fills, and
//  once the window gives a result it then goes through the 60-step restoring
//  divider, which an empty window skips. reset (synchronous, active high) clears
//  the sums and the fill count and sets the window length to 1; ring slots are
//  only used once written.
//  A held result stalls the block only when the next result is ready to go out.
//
module sliding_window_vwap
   import vwap_pkg::*;
#(
   parameter int MAX_WINDOW  = 1024,
   parameter int PRICE_BITS  = 24,
   parameter int VOLUME_BITS = 24
) (
   input  logic clock,
   input  logic reset,

   // Bar input. tdata from bit 0: high_price, low_price, close_price,
   // bar_volume, zero fill to a whole byte.
   input  logic                                                   req_tvalid,
   output logic                                                   req_tready,
   input  logic [((3*PRICE_BITS + VOLUME_BITS + 7) / 8) * 8 - 1:0] req_tdata,

   // Result output. tdata: average_price. tuser: zero_volume.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [OutWidth-1:0] rsp_tdata,
   output logic                rsp_tuser,

   // Window length register.
   input  logic                csr_wr_en,
   input  logic [CfgWidth-1:0] csr_wr_data
);

   // Typical price sum before the divide by three.
   localparam int SumW    = PRICE_BITS + 2;
   // Only the low bits of a product reach the weighted sum.
   localparam int ProdW   = (SumW + VOLUME_BITS > WsumWidth) ? WsumWidth
                                                            : SumW + VOLUME_BITS;
   localparam int SlotW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int IdxW    = ((SlotW > CfgWidth) ? SlotW : CfgWidth) + 1;
   localparam int EntryW  = ProdW + VOLUME_BITS;
   localparam logic [CfgWidth-1:0] PeriodMax =
      (MAX_WINDOW > 2047) ? {CfgWidth{1'b1}} : CfgWidth'(MAX_WINDOW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_SUB,
      ST_DEN,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CfgWidth-1:0]  window_ff, window_in;
   logic [WsumWidth-1:0] wsum_ff, wsum_in;
   logic [VsumWidth-1:0] vsum_ff, vsum_in;
   logic [CfgWidth-1:0]  bars_ff, bars_in;
   logic [SlotW-1:0]     slot_ff, slot_in;
   logic [VOLUME_BITS-1:0] vol_ff, vol_in;
   logic                 drop_ff, drop_in;
   logic [OutWidth-1:0]  res_ff, res_in;
   logic                 res_zero_ff, res_zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OutWidth-1:0]  rsp_data_ff, rsp_data_in;
   logic                 rsp_zero_ff, rsp_zero_in;

   logic [PRICE_BITS-1:0]  high_price;
   logic [PRICE_BITS-1:0]  low_price;
   logic [PRICE_BITS-1:0]  close_price;
   logic [VOLUME_BITS-1:0] bar_volume;
   logic [SumW-1:0]        price_sum;

   logic                 req_xfer;
   logic [CfgWidth-1:0]  period;
   logic [IdxW-1:0]      slot_x;
   logic [IdxW-1:0]      period_x;
   logic [IdxW-1:0]      old_x;
   logic [SlotW-1:0]     old_slot;

   logic                 mul_start;
   logic [ProdW-1:0]     product;
   unit_status_type      mul_status;
   logic                 div_start;
   logic [DenWidth-1:0]  divisor;
   logic [OutWidth-1:0]  quotient;
   unit_status_type      div_status;

   logic                 ram_wr_en;
   logic [EntryW-1:0]    ram_wr_data;
   logic [EntryW-1:0]    ram_rd_data;
   logic [ProdW-1:0]     old_product;
   logic [VOLUME_BITS-1:0] old_volume;

   // Unpack the bar fields.
   assign high_price  = req_tdata[PRICE_BITS-1:0];
   assign low_price   = req_tdata[2*PRICE_BITS-1:PRICE_BITS];
   assign close_price = req_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
   assign bar_volume  = req_tdata[3*PRICE_BITS+VOLUME_BITS-1:3*PRICE_BITS];
   assign price_sum   = SumW'(high_price) + SumW'(low_price) + SumW'(close_price);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // A window length of zero acts as one; lengths beyond the ring are
   // clamped to the ring depth.
   always_comb begin
      if (window_ff == '0) begin
         period = CfgWidth'(1);
      end else if (window_ff > PeriodMax) begin
         period = PeriodMax;
      end else begin
         period = window_ff;
      end
   end

   // Slot of the bar that leaves the window, period bars back in the ring.
   always_comb begin
      slot_x   = IdxW'(slot_ff);
      period_x = IdxW'(period);
      if (slot_x >= period_x) begin
         old_x = slot_x - period_x;
      end else begin
         old_x = slot_x + IdxW'(MAX_WINDOW) - period_x;
      end
      old_slot = old_x[SlotW-1:0];
   end

   // The multiplier starts on the accepting edge with the live bar fields.
   assign mul_start = req_xfer;

   // Divisor is three times the volume sum: the sum plus twice the sum.
   assign divisor   = DenWidth'(vsum_ff) + {1'b0, vsum_ff, 1'b0};
   assign div_start = (state_ff == ST_DEN) && (vsum_ff != '0);

   // Each ring entry holds the bar product in the low bits and the volume
   // above it. The read for the leaving bar is issued on acceptance, ahead
   // of the write to the current slot, which matters when both are the
   // same slot at a full-depth window.
   assign ram_wr_en   = (state_ff == ST_ADD);
   assign ram_wr_data = {vol_ff, product};
   assign old_product = ram_rd_data[ProdW-1:0];
   assign old_volume  = ram_rd_data[EntryW-1:ProdW];

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      wsum_in      = wsum_ff;
      vsum_in      = vsum_ff;
      bars_in      = bars_ff;
      slot_in      = slot_ff;
      vol_in       = vol_ff;
      drop_in      = drop_ff;
      res_in       = res_ff;
      res_zero_in  = res_zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_zero_in  = rsp_zero_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               vol_in   = bar_volume;
               // Once the window is full, the oldest bar is taken out.
               drop_in  = (bars_ff >= period);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_status.done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            wsum_in = wsum_ff + WsumWidth'(product);
            vsum_in = vsum_ff + VsumWidth'(vol_ff);
            if (slot_ff == SlotW'(MAX_WINDOW - 1)) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
            state_in = ST_SUB;
         end
         ST_SUB: begin
            if (drop_ff) begin
               wsum_in = wsum_ff - WsumWidth'(old_product);
               vsum_in = vsum_ff - VsumWidth'(old_volume);
            end
            if (bars_ff < period) begin
               bars_in = bars_ff + 1'b1;
            end
            // Warm-up bars give no result.
            if ((bars_ff < period) && ((bars_ff + 1'b1) < period)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            if (vsum_ff == '0) begin
               res_in      = '0;
               res_zero_in = 1'b1;
               state_in    = ST_DONE;
            end else begin
               res_zero_in = 1'b0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               res_in   = quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_zero_in  = res_zero_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new window length restarts the warm-up with empty sums.
      if (csr_wr_en) begin
         window_in = csr_wr_data;
         wsum_in   = '0;
         vsum_in   = '0;
         bars_in   = '0;
         slot_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= CfgWidth'(1);
         wsum_ff      <= '0;
         vsum_ff      <= '0;
         bars_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wsum_ff      <= wsum_in;
         vsum_ff      <= vsum_in;
         bars_ff      <= bars_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vol_ff      <= vol_in;
      drop_ff     <= drop_in;
      res_ff      <= res_in;
      res_zero_ff <= res_zero_in;
      rsp_data_ff <= rsp_data_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_zero_ff;

   vwap_serial_mul #(
      .A_W (SumW),
      .B_W (VOLUME_BITS),
      .P_W (ProdW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (price_sum),
      .mplier  (bar_volume),
      .product (product),
      .status  (mul_status)
   );

   vwap_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wsum_ff),
      .divisor  (divisor),
      .quotient (quotient),
      .status   (div_status)
   );

   vwap_ram #(
      .WIDTH (EntryW),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_xfer),
      .rd_addr (old_slot),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   // A result flagged for an empty window carries a zero price.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("zero-volume result with nonzero price");

   // The fill count never passes the window length.
   assert property (@(posedge clock) disable iff (reset)
      bars_ff <= period)
      else $error("bar count beyond window length");

   // The write slot stays inside the ring.
   assert property (@(posedge clock) disable iff (reset)
      IdxW'(slot_ff) < IdxW'(MAX_WINDOW))
      else $error("write slot outside ring");

   // While waiting for a bar, neither serial unit is running.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mul_status.busy && !div_status.busy)
      else $error("serial unit busy while idle");

   // A window length write leaves both sums empty.
   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> wsum_ff == '0 && vsum_ff == '0 && bars_ff == '0)
      else $error("sums not cleared by window length write");
`endif

endmodule
